>>> hw/rtl/pcc_pkg.sv
// shared types and constants for the pair constraint checker
package pcc_pkg;

  // default capacity of the constraint string
  localparam int unsigned MaxLenDefault = 256;

  // width of the running bracket count, kept modulo 1024
  localparam int unsigned PrefixW = 10;

  // request opcodes
  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_QUERY   = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  // constraint characters
  localparam logic [7:0] ChBar    = 8'h7C; // '|'
  localparam logic [7:0] ChCross  = 8'h78; // 'x'
  localparam logic [7:0] ChOpen   = 8'h28; // '('
  localparam logic [7:0] ChClose  = 8'h29; // ')'
  localparam logic [7:0] ChRight  = 8'h3E; // '>'
  localparam logic [7:0] ChLeft   = 8'h3C; // '<'
  localparam logic [7:0] ChDot    = 8'h2E; // '.'
  localparam logic [7:0] ChSqOpen = 8'h5B; // '['
  localparam logic [7:0] ChSqClose = 8'h5D; // ']'

  // input request payload
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [7:0] first_pos;
    logic [7:0] second_pos;
  } pcc_req_t;

  // result payload
  typedef struct packed {
    logic allowed;
    logic range_error;
  } pcc_rsp_t;

endpackage

>>> hw/rtl/pcc_ram.sv
// generic ram with one write port and two registered read ports
module pcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // write port and registered reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> hw/rtl/pair_constraint_checker.sv
// top level of the pair constraint checker
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------
//  in      | in        | in_valid_i / in_ready_o    | in_req_i
//  out     | out       | out_valid_o / out_ready_i  | out_rsp_o
//
// an append or restart request is done in the idle state; a query first reads
// both characters and both prefix entries from the two dual-read rams, then is
// evaluated into the output register in the evaluate state
// no clearing pass after reset: the running bracket count is a reset register
// a query waits in its evaluate state while the output register is still held
// appends and restarts keep flowing while a result waits to be taken
module pair_constraint_checker #(
  parameter int unsigned MaxLen = pcc_pkg::MaxLenDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pcc_pkg::pcc_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pcc_pkg::pcc_rsp_t out_rsp_o
);

  import pcc_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxLen);
  localparam int unsigned CntW  = $clog2(MaxLen + 1);
  localparam int unsigned CmpW  = (CntW > 8) ? CntW : 8;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_e;

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [PrefixW-1:0]   last_prefix_q, last_prefix_d;
  logic [AddrW-1:0]     lo_addr_q;
  logic [AddrW-1:0]     hi_addr_q;
  logic                 diag_q;
  logic                 rng_err_q;
  logic                 out_valid_q, out_valid_d;
  pcc_rsp_t             out_rsp_q, out_rsp_d;

  logic                 in_fire;
  logic                 out_free;
  logic [7:0]           lo_pos;
  logic [7:0]           hi_pos;
  logic [CmpW-1:0]      lo_ext;
  logic [CmpW-1:0]      hi_ext;
  logic [AddrW-1:0]     lo_addr;
  logic [AddrW-1:0]     hi_addr;
  logic [AddrW-1:0]     rd_lo;
  logic [AddrW-1:0]     rd_hi;
  logic                 q_rng_err;
  logic                 wr_en;
  logic [PrefixW-1:0]   prefix_next;
  logic [7:0]           ch_lo;
  logic [7:0]           ch_hi;
  logic [PrefixW-1:0]   pre_lo;
  logic [PrefixW-1:0]   pre_hi;
  logic                 rule_ok;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  // order the queried positions as lower, higher
  assign lo_pos    = (in_req_i.first_pos < in_req_i.second_pos) ?
                     in_req_i.first_pos : in_req_i.second_pos;
  assign hi_pos    = (in_req_i.first_pos < in_req_i.second_pos) ?
                     in_req_i.second_pos : in_req_i.first_pos;
  assign lo_ext    = CmpW'(lo_pos);
  assign hi_ext    = CmpW'(hi_pos);
  assign lo_addr   = lo_ext[AddrW-1:0];
  assign hi_addr   = hi_ext[AddrW-1:0];
  assign q_rng_err = (hi_ext >= CmpW'(count_q));

  // read addresses follow the request on accept and are held while evaluating
  assign rd_lo = (state_q == ST_IDLE) ? lo_addr : lo_addr_q;
  assign rd_hi = (state_q == ST_IDLE) ? hi_addr : hi_addr_q;

  // next bracket count for an append
  always_comb begin
    prefix_next = last_prefix_q;
    if (in_req_i.char_code == ChSqOpen) begin
      prefix_next = last_prefix_q + PrefixW'(1);
    end else if (in_req_i.char_code == ChSqClose) begin
      prefix_next = last_prefix_q - PrefixW'(1);
    end
  end

  assign wr_en = in_fire && (in_req_i.opcode == OP_APPEND) &&
                 (count_q < CntW'(MaxLen));

  // character store, entry k holds character k
  pcc_ram #(
    .Width (8),
    .Depth (MaxLen),
    .AddrW (AddrW)
  ) u_char_ram (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (count_q[AddrW-1:0]),
    .wdata_i   (in_req_i.char_code),
    .raddr_a_i (rd_lo),
    .raddr_b_i (rd_hi),
    .rdata_a_o (ch_lo),
    .rdata_b_o (ch_hi)
  );

  // prefix store, entry k holds the count over characters 0..k
  pcc_ram #(
    .Width (PrefixW),
    .Depth (MaxLen),
    .AddrW (AddrW)
  ) u_prefix_ram (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (count_q[AddrW-1:0]),
    .wdata_i   (prefix_next),
    .raddr_a_i (rd_lo),
    .raddr_b_i (rd_hi - AddrW'(1)),
    .rdata_a_o (pre_lo),
    .rdata_b_o (pre_hi)
  );

  // pairing rules, first match wins
  always_comb begin
    rule_ok = 1'b0;
    if (diag_q) begin
      rule_ok = (ch_lo != ChBar);
    end else if (ch_lo == ChCross || ch_hi == ChCross) begin
      rule_ok = 1'b0;
    end else if ((ch_lo == ChOpen && ch_hi == ChClose) ||
                 (ch_lo == ChClose && ch_hi == ChOpen)) begin
      rule_ok = 1'b1;
    end else if (ch_lo == ChRight) begin
      rule_ok = 1'b0;
    end else if ((ch_lo == ChDot || ch_lo == ChLeft) &&
                 (ch_hi == ChDot || ch_hi == ChRight)) begin
      rule_ok = 1'b1;
    end else if (ch_lo == ChSqOpen && ch_hi == ChSqClose) begin
      rule_ok = (pre_lo == pre_hi);
    end
  end

  // control sequencing and string bookkeeping
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    last_prefix_d = last_prefix_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    out_rsp_d     = out_rsp_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_req_i.opcode)
            OP_APPEND: begin
              if (wr_en) begin
                count_d       = count_q + CntW'(1);
                last_prefix_d = prefix_next;
              end
            end
            OP_QUERY: begin
              state_d = ST_EVAL;
            end
            OP_RESTART: begin
              count_d       = '0;
              last_prefix_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_rsp_d.allowed     = ~rng_err_q & rule_ok;
          out_rsp_d.range_error = rng_err_q;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      last_prefix_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      last_prefix_q <= last_prefix_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // query payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire && in_req_i.opcode == OP_QUERY) begin
      lo_addr_q <= lo_addr;
      hi_addr_q <= hi_addr;
      diag_q    <= (lo_pos == hi_pos);
      rng_err_q <= q_rng_err;
    end
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

>>> test/tb_top.sv
// self-checking testbench for the pair constraint checker
`timescale 1ns / 1ps

module tb_top;
  import pcc_pkg::*;

  localparam int unsigned MaxLen = 256;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ProbeRows = 25;
  localparam int unsigned PhaseItems = 600;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ReportMax = 10;
  // request code the block leaves unused
  localparam logic [1:0] OpUnused = 2'd3;

  // directed probe: request plus an optional hand-written verdict
  typedef struct packed {
    pcc_req_t req;
    logic     typed;
    pcc_rsp_t rsp;
  } probe_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  pcc_req_t in_req;
  logic     out_valid;
  logic     out_ready;
  pcc_rsp_t out_rsp;

  // shadow copy of the constraint string and its bracket balance
  logic [7:0]         shadow_chars [MaxLen];
  logic [PrefixW-1:0] shadow_bal [MaxLen+1];
  int unsigned        shadow_len;

  pcc_rsp_t    verdict_q [$];
  int unsigned live_items = 0;
  int unsigned fault_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_gap_pct = 15;
  int unsigned recv_stall_pct = 64;

  // directed requests; typed verdicts only where obvious
  probe_row_t probe_tab [ProbeRows] = '{
    '{'{OP_QUERY,   8'h00,     8'h00, 8'h00}, 1'b1, '{1'b0, 1'b1}},
    '{'{OP_APPEND,  ChBar,     8'hFF, 8'hFF}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_QUERY,   8'h00,     8'h00, 8'h00}, 1'b1, '{1'b0, 1'b0}},
    '{'{OP_RESTART, 8'hFF,     8'hFF, 8'hFF}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_APPEND,  ChDot,     8'h00, 8'h00}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_APPEND,  ChCross,   8'h00, 8'h00}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_APPEND,  ChOpen,    8'h00, 8'h00}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_APPEND,  ChClose,   8'h00, 8'h00}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_APPEND,  ChRight,   8'h00, 8'h00}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_APPEND,  ChSqOpen,  8'h00, 8'h00}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_APPEND,  ChLeft,    8'h00, 8'h00}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_APPEND,  ChSqClose, 8'h00, 8'h00}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_APPEND,  8'hFF,     8'h00, 8'h00}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_APPEND,  ChOpen,    8'h00, 8'h00}, 1'b0, '{1'b0, 1'b0}},
    '{'{OpUnused,   8'hFF,     8'hFF, 8'hFF}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_QUERY,   8'h00,     8'd1,  8'd0 }, 1'b1, '{1'b0, 1'b0}},
    '{'{OP_QUERY,   8'h00,     8'd3,  8'd2 }, 1'b1, '{1'b1, 1'b0}},
    '{'{OP_QUERY,   8'h00,     8'd3,  8'd9 }, 1'b1, '{1'b1, 1'b0}},
    '{'{OP_QUERY,   8'h00,     8'd4,  8'd7 }, 1'b1, '{1'b0, 1'b0}},
    '{'{OP_QUERY,   8'h00,     8'd0,  8'd4 }, 1'b1, '{1'b1, 1'b0}},
    '{'{OP_QUERY,   8'h00,     8'd5,  8'd7 }, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_QUERY,   8'h00,     8'd6,  8'd8 }, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_QUERY,   8'hFF,     8'd10, 8'd9 }, 1'b1, '{1'b0, 1'b1}},
    '{'{OP_QUERY,   8'h00,     8'd255, 8'd0}, 1'b1, '{1'b0, 1'b1}},
    '{'{OP_QUERY,   8'h00,     8'd0,  8'd0 }, 1'b1, '{1'b1, 1'b0}}
  };

  pair_constraint_checker #(
    .MaxLen(MaxLen)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic pcc_req_t mk_req(logic [1:0] op, logic [7:0] ch, logic [7:0] f,
                                      logic [7:0] s);
    pcc_req_t r;
    r.opcode = op;
    r.char_code = ch;
    r.first_pos = f;
    r.second_pos = s;
    return r;
  endfunction

  // pairing verdict for two positions of the shadow string
  function automatic pcc_rsp_t pair_verdict(int unsigned f, int unsigned s);
    int unsigned        lo;
    int unsigned        hi;
    logic [7:0]         a;
    logic [7:0]         b;
    logic [PrefixW-1:0] net;
    pcc_rsp_t           r;
    lo = (f < s) ? f : s;
    hi = (f < s) ? s : f;
    r = '0;
    if (hi >= shadow_len) begin
      r.range_error = 1'b1;
      return r;
    end
    a = shadow_chars[lo];
    b = shadow_chars[hi];
    if (lo == hi) begin
      r.allowed = (a != ChBar);
    end else if (a == ChCross || b == ChCross) begin
      r.allowed = 1'b0;
    end else if ((a == ChOpen && b == ChClose) || (a == ChClose && b == ChOpen)) begin
      r.allowed = 1'b1;
    end else if (a == ChRight) begin
      r.allowed = 1'b0;
    end else if ((a == ChDot || a == ChLeft) && (b == ChDot || b == ChRight)) begin
      r.allowed = 1'b1;
    end else if (a == ChSqOpen && b == ChSqClose) begin
      // net balance strictly between the two, nesting not checked
      net = shadow_bal[hi] - shadow_bal[lo+1];
      r.allowed = (net == '0);
    end
    return r;
  endfunction

  // update the shadow state for an accepted request, queue any verdict
  task automatic absorb_request(pcc_req_t req, logic typed, pcc_rsp_t rsp);
    logic [PrefixW-1:0] bal;
    case (req.opcode)
      OP_APPEND: begin
        if (shadow_len < MaxLen) begin
          bal = shadow_bal[shadow_len];
          if (req.char_code == ChSqOpen) bal = bal + PrefixW'(1);
          else if (req.char_code == ChSqClose) bal = bal - PrefixW'(1);
          shadow_chars[shadow_len] = req.char_code;
          shadow_bal[shadow_len+1] = bal;
          shadow_len++;
          live_items++;
        end
      end
      OP_RESTART: begin
        shadow_len = 0;
        shadow_bal[0] = '0;
        live_items++;
      end
      OP_QUERY: begin
        verdict_q.push_back(typed ? rsp :
                            pair_verdict(32'(req.first_pos), 32'(req.second_pos)));
        live_items++;
      end
      default: ;
    endcase
  endtask

  // present one request, with random idle cycles ahead of it
  task automatic send_req(pcc_req_t req, logic typed, pcc_rsp_t rsp);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (!in_ready);
    absorb_request(req, typed, rsp);
  endtask

  function automatic logic [7:0] pick_char(logic brackety);
    logic [7:0] glyphs [9] = '{ChBar, ChCross, ChOpen, ChClose, ChRight, ChLeft, ChDot,
                               ChSqOpen, ChSqClose};
    if (brackety && $urandom_range(9) < 6) return $urandom_range(1) ? ChSqOpen : ChSqClose;
    if ($urandom_range(99) < 85) return glyphs[$urandom_range(8)];
    return 8'($urandom_range(255));
  endfunction

  // mostly restart, load, query sequences; some raw noise in between
  task automatic random_phase(int unsigned n_live);
    int unsigned stop_at;
    int unsigned seq_no;
    int unsigned len;
    int unsigned pick;
    int unsigned f;
    int unsigned s;
    logic        brackety;
    stop_at = live_items + n_live;
    seq_no = 0;
    while (live_items < stop_at) begin
      seq_no++;
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_req(mk_req(2'($urandom_range(3)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), 8'($urandom_range(255))), 1'b0, '0);
        end
      end else begin
        send_req(mk_req(OP_RESTART, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255))), 1'b0, '0);
        // now and then fill to capacity and push past it
        len = (seq_no % 12 == 5) ? MaxLen + $urandom_range(1, 4) : $urandom_range(1, 24);
        brackety = ($urandom_range(2) == 0);
        repeat (len) begin
          send_req(mk_req(OP_APPEND, pick_char(brackety), 8'($urandom_range(255)),
                          8'($urandom_range(255))), 1'b0, '0);
        end
        repeat ($urandom_range(3, 16)) begin
          pick = $urandom_range(9);
          if (pick < 7) begin
            f = $urandom_range(shadow_len - 1);
            s = $urandom_range(shadow_len - 1);
          end else if (pick == 7) begin
            f = $urandom_range(shadow_len - 1);
            s = f;
          end else begin
            f = $urandom_range(255);
            s = $urandom_range(255);
          end
          send_req(mk_req(OP_QUERY, 8'($urandom_range(255)), 8'(f), 8'(s)), 1'b0, '0);
        end
      end
    end
  endtask

  task automatic note_fault(string msg);
    fault_cnt++;
    if (fault_cnt <= ReportMax) $display("%0t: %s", $realtime, msg);
  endtask

  // result side: random stalls, compare against the oldest verdict
  initial begin
    pcc_rsp_t want;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          note_fault($sformatf("unexpected result allowed=%0b range_error=%0b",
                               out_rsp.allowed, out_rsp.range_error));
        end else begin
          want = verdict_q.pop_front();
          if (out_rsp.allowed !== want.allowed)
            note_fault($sformatf("allowed: expected %0b, got %0b",
                                 want.allowed, out_rsp.allowed));
          if (out_rsp.range_error !== want.range_error)
            note_fault($sformatf("range_error: expected %0b, got %0b",
                                 want.range_error, out_rsp.range_error));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // request side: reset, directed probe, then three random phases
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    shadow_len = 0;
    shadow_bal[0] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probe_tab[i]) send_req(probe_tab[i].req, probe_tab[i].typed, probe_tab[i].rsp);
    random_phase(PhaseItems);

    send_gap_pct = 64;
    recv_stall_pct = 15;
    random_phase(PhaseItems);

    send_gap_pct = 0;
    recv_stall_pct = 0;
    random_phase(PhaseItems);

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fault_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/pcc_pkg.sv
hw/rtl/pcc_ram.sv
hw/rtl/pair_constraint_checker.sv
test/tb_top.sv
